// ===== rtl/tsma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsma_pkg - shared constants and types
// Field widths, reset values and the stage payload of the throttled sample
// moving average unit.
// ----------------------------------------------------------------------------
package tsma_pkg;

    localparam int TIME_W   = 32;
    localparam int DATA_W   = 32;
    localparam int SEQ_W    = 32;
    localparam int REASON_W = 8;

    localparam int WINDOW_LEN_DEF = 12;

    localparam logic [TIME_W-1:0]   KEEPALIVE_RST = TIME_W'(1000);
    localparam logic [REASON_W-1:0] REASON_NONE   = '0;

    // result fields that ride along the averaging pipeline
    typedef struct packed {
        logic [TIME_W-1:0]   stamp_ms;
        logic [SEQ_W-1:0]    sequence_number;
        logic                valid_out;
        logic [DATA_W-1:0]   distance_out;
        logic [DATA_W-1:0]   weight_out;
        logic [REASON_W-1:0] reason_out;
        logic                average_ready;
    } t_pass;

endpackage
`default_nettype wire

// ===== rtl/tsma_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsma_in_if - sample input channel
// Valid/ready channel carrying one timestamped sample per transfer.
// ----------------------------------------------------------------------------
interface tsma_in_if;
    import tsma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [TIME_W-1:0]          time_ms;
    logic                       sample_valid;
    logic signed [DATA_W-1:0]   distance_in;
    logic signed [DATA_W-1:0]   weight_in;
    logic [REASON_W-1:0]        reason_code;

    modport source (
        output valid, time_ms, sample_valid, distance_in, weight_in, reason_code,
        input  ready
    );

    modport sink (
        input  valid, time_ms, sample_valid, distance_in, weight_in, reason_code,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/tsma_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsma_out_if - result output channel
// Valid/ready channel carrying one emitted sample with its window average.
// ----------------------------------------------------------------------------
interface tsma_out_if;
    import tsma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [TIME_W-1:0]          stamp_ms;
    logic [SEQ_W-1:0]           sequence_number;
    logic                       valid_out;
    logic signed [DATA_W-1:0]   distance_out;
    logic signed [DATA_W-1:0]   weight_out;
    logic                       average_ready;
    logic signed [DATA_W-1:0]   average_weight;
    logic [REASON_W-1:0]        reason_out;

    modport source (
        output valid, stamp_ms, sequence_number, valid_out, distance_out,
               weight_out, average_ready, average_weight, reason_out,
        input  ready
    );

    modport sink (
        input  valid, stamp_ms, sequence_number, valid_out, distance_out,
               weight_out, average_ready, average_weight, reason_out,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/tsma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsma_front - input register, throttle and weight window
// Registers each sample, decides whether it is emitted, updates the weight
// ring and running sum, and hands emitted items on with their new sum.
// ----------------------------------------------------------------------------
module tsma_front #(
    parameter int WINDOW_LEN = tsma_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                                   i_clk,
    input  wire logic                                                   i_rst_n,
    input  wire logic [tsma_pkg::TIME_W-1:0]                            i_keepalive,
    tsma_in_if.sink                                                     i_in,
    output      logic                                                   o_b_valid,
    input  wire logic                                                   i_b_ready,
    output      tsma_pkg::t_pass                                        o_b_data,
    output      logic signed [tsma_pkg::DATA_W+$clog2(WINDOW_LEN)-1:0]  o_b_sum
);
    import tsma_pkg::*;

    localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_LEN - 1);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(WINDOW_LEN);
    localparam logic [FILL_W-1:0] ALMOST    = FILL_W'(WINDOW_LEN - 1);

    // input register
    logic                      r_a_vld;
    logic [TIME_W-1:0]         r_a_time;
    logic                      r_a_valid;
    logic [DATA_W-1:0]         r_a_dist;
    logic signed [DATA_W-1:0]  r_a_wt;
    logic [REASON_W-1:0]       r_a_reason;

    // filter state
    logic signed [DATA_W-1:0]  r_ring [WINDOW_LEN];
    logic [IDX_W-1:0]          r_head;
    logic [FILL_W-1:0]         r_fill;
    logic signed [SUM_W-1:0]   r_sum;
    logic [TIME_W-1:0]         r_last_time;
    logic [REASON_W-1:0]       r_last_reason;
    logic [SEQ_W-1:0]          r_emit_cnt;

    // hand-off register
    logic                      r_b_vld;
    t_pass                     r_b_data;
    logic signed [SUM_W-1:0]   r_b_sum;

    logic                      a_rdy;
    logic                      b_rdy;
    logic                      a_leave;
    logic [TIME_W-1:0]         elapsed;
    logic                      emit;
    logic                      full;
    logic signed [SUM_W-1:0]   old_w;
    logic signed [SUM_W-1:0]   n_sum;
    logic [FILL_W-1:0]         n_fill;
    logic [IDX_W-1:0]          n_head;
    logic [SEQ_W-1:0]          n_seq;
    logic                      n_avg_rdy;
    t_pass                     n_b_data;

    assign b_rdy      = !r_b_vld || i_b_ready;
    assign a_rdy      = !r_a_vld || b_rdy;
    assign a_leave    = r_a_vld && b_rdy;
    assign i_in.ready = a_rdy;

    always_comb begin
        elapsed   = r_a_time - r_last_time;
        // repeated invalid reason inside the keepalive window is dropped
        emit      = r_a_valid || (r_a_reason != r_last_reason) || (elapsed >= i_keepalive);
        full      = (r_fill == FULL_CNT);
        old_w     = full ? SUM_W'(r_ring[r_head]) : '0;
        n_sum     = r_sum + SUM_W'(r_a_wt) - old_w;
        n_fill    = full ? r_fill : r_fill + 1'b1;
        n_head    = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        n_seq     = r_emit_cnt + 1'b1;
        n_avg_rdy = r_a_valid && (full || (r_fill == ALMOST));

        n_b_data.stamp_ms        = r_a_time;
        n_b_data.sequence_number = n_seq;
        n_b_data.valid_out       = r_a_valid;
        n_b_data.distance_out    = r_a_dist;
        n_b_data.weight_out      = r_a_wt;
        n_b_data.reason_out      = r_a_valid ? REASON_NONE : r_a_reason;
        n_b_data.average_ready   = n_avg_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_head        <= '0;
            r_fill        <= '0;
            r_sum         <= '0;
            r_last_time   <= '0;
            r_last_reason <= REASON_NONE;
            r_emit_cnt    <= '0;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_in.valid;
            end
            if (b_rdy) begin
                r_b_vld <= r_a_vld && emit;
            end
            if (a_leave && r_a_valid) begin
                r_head        <= n_head;
                r_fill        <= n_fill;
                r_sum         <= n_sum;
                r_last_reason <= REASON_NONE;
            end
            if (a_leave && !r_a_valid && emit) begin
                r_last_time   <= r_a_time;
                r_last_reason <= r_a_reason;
            end
            if (a_leave && emit) begin
                r_emit_cnt <= n_seq;
            end
        end
    end

    // payload registers and ring storage
    always_ff @(posedge i_clk) begin
        if (i_in.valid && a_rdy) begin
            r_a_time   <= i_in.time_ms;
            r_a_valid  <= i_in.sample_valid;
            r_a_dist   <= i_in.distance_in;
            r_a_wt     <= i_in.weight_in;
            r_a_reason <= i_in.reason_code;
        end
        if (a_leave && emit) begin
            r_b_data <= n_b_data;
            r_b_sum  <= n_sum;
        end
        if (a_leave && r_a_valid) begin
            r_ring[r_head] <= r_a_wt;
        end
    end

    assign o_b_valid = r_b_vld;
    assign o_b_data  = r_b_data;
    assign o_b_sum   = r_b_sum;

endmodule
`default_nettype wire

// ===== rtl/tsma_avg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsma_avg_div - window sum to mean
// Divides the running sum by the window length (truncating toward zero)
// with a split reciprocal multiply over four registered stages.
// ----------------------------------------------------------------------------
module tsma_avg_div #(
    parameter int WINDOW_LEN = tsma_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                                   i_clk,
    input  wire logic                                                   i_rst_n,
    input  wire logic                                                   i_b_valid,
    output      logic                                                   o_b_ready,
    input  wire tsma_pkg::t_pass                                        i_b_data,
    input  wire logic signed [tsma_pkg::DATA_W+$clog2(WINDOW_LEN)-1:0]  i_b_sum,
    tsma_out_if.source                                                  o_out
);
    import tsma_pkg::*;

    localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
    localparam int SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam int MW     = SUM_W + 1;
    localparam int MLO_W  = MW / 2;
    localparam int MHI_W  = MW - MLO_W;
    localparam int PLO_W  = SUM_W + MLO_W;
    localparam int PHI_W  = SUM_W + MHI_W;
    localparam int PROD_W = SUM_W + MW;
    // ceil(2^SHIFT / WINDOW_LEN): exact quotient for any SUM_W-bit magnitude
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [MLO_W-1:0] RECIP_LO = RECIP[MLO_W-1:0];
    localparam logic [MHI_W-1:0] RECIP_HI = RECIP[MW-1:MLO_W];

    logic               r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    t_pass              r_c_pay, r_d_pay, r_e_pay, r_f_pay;
    logic               r_c_neg, r_d_neg, r_e_neg;
    logic [SUM_W-1:0]   r_c_mag;
    logic [PLO_W-1:0]   r_d_plo;
    logic [PHI_W-1:0]   r_d_phi;
    logic [DATA_W-1:0]  r_e_q;
    logic [DATA_W-1:0]  r_f_avg;

    logic               c_rdy, d_rdy, e_rdy, f_rdy;
    logic [SUM_W-1:0]   n_c_mag;
    logic [PLO_W-1:0]   n_d_plo;
    logic [PHI_W-1:0]   n_d_phi;
    logic [PROD_W-1:0]  n_e_full;
    logic [DATA_W-1:0]  n_e_q;
    logic [DATA_W-1:0]  n_f_avg;

    assign f_rdy     = !r_f_vld || o_out.ready;
    assign e_rdy     = !r_e_vld || f_rdy;
    assign d_rdy     = !r_d_vld || e_rdy;
    assign c_rdy     = !r_c_vld || d_rdy;
    assign o_b_ready = c_rdy;

    always_comb begin
        n_c_mag  = i_b_sum[SUM_W-1] ? $unsigned(~i_b_sum + 1'b1) : $unsigned(i_b_sum);
        n_d_plo  = PLO_W'(r_c_mag) * PLO_W'(RECIP_LO);
        n_d_phi  = PHI_W'(r_c_mag) * PHI_W'(RECIP_HI);
        n_e_full = PROD_W'(r_d_plo) + (PROD_W'(r_d_phi) << MLO_W);
        n_e_q    = DATA_W'(n_e_full >> SHIFT);
        n_f_avg  = !r_e_pay.average_ready ? '0 :
                   (r_e_neg ? (~r_e_q + 1'b1) : r_e_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (c_rdy) r_c_vld <= i_b_valid;
            if (d_rdy) r_d_vld <= r_c_vld;
            if (e_rdy) r_e_vld <= r_d_vld;
            if (f_rdy) r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy && i_b_valid) begin
            r_c_pay <= i_b_data;
            r_c_neg <= i_b_sum[SUM_W-1];
            r_c_mag <= n_c_mag;
        end
        if (d_rdy && r_c_vld) begin
            r_d_pay <= r_c_pay;
            r_d_neg <= r_c_neg;
            r_d_plo <= n_d_plo;
            r_d_phi <= n_d_phi;
        end
        if (e_rdy && r_d_vld) begin
            r_e_pay <= r_d_pay;
            r_e_neg <= r_d_neg;
            r_e_q   <= n_e_q;
        end
        if (f_rdy && r_e_vld) begin
            r_f_pay <= r_e_pay;
            r_f_avg <= n_f_avg;
        end
    end

    assign o_out.valid           = r_f_vld;
    assign o_out.stamp_ms        = r_f_pay.stamp_ms;
    assign o_out.sequence_number = r_f_pay.sequence_number;
    assign o_out.valid_out       = r_f_pay.valid_out;
    assign o_out.distance_out    = r_f_pay.distance_out;
    assign o_out.weight_out      = r_f_pay.weight_out;
    assign o_out.average_ready   = r_f_pay.average_ready;
    assign o_out.average_weight  = r_f_avg;
    assign o_out.reason_out      = r_f_pay.reason_out;

endmodule
`default_nettype wire

// ===== rtl/throttled_sample_moving_average_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// throttled_sample_moving_average_unit - throttled sample stream with mean
// Usage:
//   i_in  : one sample per transfer (valid & ready high at a rising edge).
//   o_out : zero or one result per sample. Valid samples always produce a
//           result; invalid samples only when the reason changes or the
//           keepalive interval has run out since the last invalid result.
//   cfg   : i_cfg_we / i_cfg_wdata load the keepalive interval (ms); write
//           only while no samples are in flight.
// Pipeline: a result passes the input register, throttle/window stage,
//           three divide stages and the output register.
// Throughput: one sample per cycle unless stalled; a single add/subtract for the
//           running sum, pipelined reciprocal-multiply divide; nothing iterates.
// Reset : synchronous, active low. Clears the pipeline, window fill, sum,
//           sequence counter and throttle history; keepalive returns to 1000.
//           The ring is not cleared; entries are read only once it is full.
// Stall : when o_out.ready is low the stages fill up behind the output
//           register and i_in.ready drops once every stage is occupied;
//           no sample is lost or duplicated.
// ----------------------------------------------------------------------------
module throttled_sample_moving_average_unit #(
    parameter int WINDOW_LEN = tsma_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsma_pkg::TIME_W-1:0]    i_cfg_wdata,
    tsma_in_if.sink                             i_in,
    tsma_out_if.source                          o_out
);
    import tsma_pkg::*;

    localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);

    // keepalive configuration register
    logic [TIME_W-1:0]        r_keepalive;

    // throttle stage -> divide pipeline
    logic                     b_valid;
    logic                     b_ready;
    t_pass                    b_data;
    logic signed [SUM_W-1:0]  b_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive <= KEEPALIVE_RST;
        end else if (i_cfg_we) begin
            r_keepalive <= i_cfg_wdata;
        end
    end

    // throttle decision, sequence numbering, weight ring and running sum
    tsma_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_keepalive (r_keepalive),
        .i_in        (i_in),
        .o_b_valid   (b_valid),
        .i_b_ready   (b_ready),
        .o_b_data    (b_data),
        .o_b_sum     (b_sum)
    );

    // sum / WINDOW_LEN and output register
    tsma_avg_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_avg_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_b_valid (b_valid),
        .o_b_ready (b_ready),
        .i_b_data  (b_data),
        .i_b_sum   (b_sum),
        .o_out     (o_out)
    );

    // an average is only ever reported for a valid sample
    a_avg_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.average_ready |-> o_out.valid_out)
        else $error("average reported for invalid sample");

    // no average yet means the average field reads zero
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.average_ready |-> o_out.average_weight == '0)
        else $error("average nonzero while not ready");

    // valid results carry no reason code
    a_valid_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.valid_out |-> o_out.reason_out == REASON_NONE)
        else $error("reason code on valid result");

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result presented right after reset");

endmodule
`default_nettype wire
